[rtl/slcfp_pkg.sv]
`default_nettype none
package slcfp_pkg;

    localparam int MAX_FRAME   = 32;
    localparam int FRAME_AW    = $clog2(MAX_FRAME);
    localparam int RES_MAX     = 64;
    localparam int EV_AW       = $clog2(RES_MAX);

    localparam logic [7:0]  SYNC_RESET = 8'hAA;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_GOOD    = 3'd1;
    localparam logic [2:0] EV_BAD_LEN = 3'd2;
    localparam logic [2:0] EV_BAD_CRC = 3'd3;
    localparam logic [2:0] EV_GAP     = 3'd4;

    localparam logic [1:0] REG_SYNC = 2'd0;
    localparam logic [1:0] REG_MIN  = 2'd1;
    localparam logic [1:0] REG_MAX  = 2'd2;

    typedef struct packed {
        logic [2:0] kind;
        logic [5:0] flen;
        logic [4:0] idx;
        logic [7:0] val;
    } ev_t;

    function automatic logic [15:0] crc_upd(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

[rtl/slcfp_ram.sv]
`default_nettype none
module slcfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[rtl/sync_length_crc16_frame_parser_unit.sv]
`default_nettype none
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  func, data_byte
// result    out        out_valid/out_stall  event_kind .. count_gap_resets
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A transaction is accepted in idle and passes a check state; each replayed byte is read
// and handled, a good frame is emitted byte by byte, and one failing its CRC is copied for replay.
// Each result is read from the registered event memory (S_OUTRD, S_OUTLD) and held
// in S_OUTWT for every cycle in which out_stall is held.
// The input stalls from acceptance until the last result of the transaction is taken.
// Reset clears the parser state and counters; the memories need no clearing.
module sync_length_crc16_frame_parser_unit
    import slcfp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        func,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       event_kind,
    output logic [5:0]       frame_len,
    output logic [4:0]       byte_index,
    output logic [7:0]       byte_value,
    output logic             last,
    output logic             idle,
    output logic [31:0]      count_bytes_received,
    output logic [31:0]      count_bytes_discarded,
    output logic [31:0]      count_length_errors,
    output logic [31:0]      count_frames_ok,
    output logic [31:0]      count_crc_errors,
    output logic [31:0]      count_gap_resets,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHK    = 4'd1;
    localparam logic [3:0] S_RPLREQ = 4'd2;
    localparam logic [3:0] S_RPLBYT = 4'd3;
    localparam logic [3:0] S_EMIT   = 4'd4;
    localparam logic [3:0] S_COPY   = 4'd5;
    localparam logic [3:0] S_OUTRD  = 4'd6;
    localparam logic [3:0] S_OUTLD  = 4'd7;
    localparam logic [3:0] S_OUTWT  = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic [7:0]  sync_reg;
    logic [5:0]  min_reg, max_reg;
    logic [5:0]  fill_reg, fill_next;
    logic [5:0]  exp_reg, exp_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  lo_reg, lo_next;
    logic [5:0]  len_reg, len_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [4:0]  rq_head_reg, rq_head_next;
    logic [5:0]  rq_len_reg, rq_len_next;
    logic [6:0]  ev_cnt_reg, ev_cnt_next;
    logic [5:0]  out_idx_reg, out_idx_next;
    logic [31:0] rcv_reg, rcv_next;
    logic [31:0] disc_reg, disc_next;
    logic [31:0] lerr_reg, lerr_next;
    logic [31:0] good_reg, good_next;
    logic [31:0] cerr_reg, cerr_next;
    logic [31:0] gap_reg, gap_next;
    logic        out_valid_reg, out_valid_next;
    ev_t         out_ev_reg, out_ev_next;
    logic        out_last_reg, out_last_next;

    logic                fm_we;
    logic [FRAME_AW-1:0] fm_waddr, fm_raddr;
    logic [7:0]          fm_wdata, fm_rdata;
    logic                rq_we;
    logic [FRAME_AW-1:0] rq_waddr, rq_raddr;
    logic [7:0]          rq_wdata, rq_rdata;
    logic                ev_we;
    logic [EV_AW-1:0]    ev_waddr, ev_raddr;
    ev_t                 ev_wdata, ev_rdata;

    logic        do_handle;
    logic [7:0]  hb;
    logic [4:0]  head_base;
    logic [5:0]  len_base;
    logic        ev_add;
    ev_t         ev_new;
    logic        len_ok;
    logic [5:0]  nm1;
    logic [5:0]  room;
    logic [5:0]  keep;
    logic [6:0]  n_out;

    slcfp_ram #(.WIDTH(8), .DEPTH(MAX_FRAME)) u_frame (
        .clk(clk), .we(fm_we), .waddr(fm_waddr), .wdata(fm_wdata),
        .raddr(fm_raddr), .rdata(fm_rdata)
    );

    slcfp_ram #(.WIDTH(8), .DEPTH(MAX_FRAME)) u_replay (
        .clk(clk), .we(rq_we), .waddr(rq_waddr), .wdata(rq_wdata),
        .raddr(rq_raddr), .rdata(rq_rdata)
    );

    slcfp_ram #(.WIDTH($bits(ev_t)), .DEPTH(RES_MAX)) u_events (
        .clk(clk), .we(ev_we), .waddr(ev_waddr), .wdata(ev_wdata),
        .raddr(ev_raddr), .rdata(ev_rdata)
    );

    assign n_out = (ev_cnt_reg == 7'd0) ? 7'd1 : ev_cnt_reg;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        exp_next       = exp_reg;
        crc_next       = crc_reg;
        lo_next        = lo_reg;
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        rq_head_next   = rq_head_reg;
        rq_len_next    = rq_len_reg;
        ev_cnt_next    = ev_cnt_reg;
        out_idx_next   = out_idx_reg;
        rcv_next       = rcv_reg;
        disc_next      = disc_reg;
        lerr_next      = lerr_reg;
        good_next      = good_reg;
        cerr_next      = cerr_reg;
        gap_next       = gap_reg;
        out_valid_next = out_valid_reg;
        out_ev_next    = out_ev_reg;
        out_last_next  = out_last_reg;

        fm_we    = 1'b0;
        fm_waddr = fill_reg[FRAME_AW-1:0];
        fm_wdata = 8'd0;
        fm_raddr = cnt_reg[FRAME_AW-1:0];
        rq_we    = 1'b0;
        rq_waddr = rq_head_reg + cnt_reg[FRAME_AW-1:0] - 5'd2;
        rq_wdata = fm_rdata;
        rq_raddr = rq_head_reg;
        ev_raddr = out_idx_reg;

        do_handle = 1'b0;
        hb        = data_byte;
        head_base = rq_head_reg;
        len_base  = rq_len_reg;
        ev_add    = 1'b0;
        ev_new    = '0;
        len_ok    = 1'b0;
        nm1       = 6'd0;
        room      = 6'd0;
        keep      = 6'd0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (func)
                    begin
                        if (fill_reg != 6'd0)
                        begin
                            ev_add    = 1'b1;
                            ev_new    = '{kind: EV_GAP, flen: fill_reg, idx: 5'd0, val: 8'd0};
                            gap_next  = gap_reg + 32'd1;
                            disc_next = disc_reg + {26'd0, fill_reg};
                            fill_next = 6'd0;
                            exp_next  = 6'd0;
                        end
                        state_next = S_CHK;
                    end
                    else
                    begin
                        rcv_next  = rcv_reg + 32'd1;
                        do_handle = 1'b1;
                        hb        = data_byte;
                    end
                end
            end
            S_CHK:
            begin
                out_idx_next = 6'd0;
                state_next   = (rq_len_reg != 6'd0) ? S_RPLREQ : S_OUTRD;
            end
            S_RPLREQ:
            begin
                state_next = S_RPLBYT;
            end
            S_RPLBYT:
            begin
                do_handle = 1'b1;
                hb        = rq_rdata;
                head_base = rq_head_reg + 5'd1;
                len_base  = rq_len_reg - 6'd1;
            end
            S_EMIT:
            begin
                if (cnt_reg != 6'd0)
                begin
                    ev_add = 1'b1;
                    ev_new = '{kind: EV_GOOD, flen: len_reg,
                               idx: cnt_reg[4:0] - 5'd1, val: fm_rdata};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == len_reg)
                begin
                    state_next = S_CHK;
                end
            end
            S_COPY:
            begin
                rq_we    = (cnt_reg >= 6'd2);
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == len_reg)
                begin
                    state_next = S_CHK;
                end
            end
            S_OUTRD:
            begin
                state_next = S_OUTLD;
            end
            S_OUTLD:
            begin
                out_ev_next    = (ev_cnt_reg == 7'd0) ? ev_t'('0) : ev_rdata;
                out_last_next  = ({1'b0, out_idx_reg} + 7'd1 == n_out);
                out_valid_next = 1'b1;
                state_next     = S_OUTWT;
            end
            S_OUTWT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        ev_cnt_next = 7'd0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + 6'd1;
                        state_next   = S_OUTRD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (do_handle)
        begin
            rq_head_next = head_base;
            rq_len_next  = len_base;
            state_next   = S_CHK;
            fm_wdata     = hb;
            len_ok = (hb >= 8'd4) && (hb >= {2'b00, min_reg}) &&
                     (hb <= {2'b00, max_reg}) && (hb <= 8'(MAX_FRAME));
            if (fill_reg == 6'd0)
            begin
                if (hb == sync_reg)
                begin
                    fm_we     = 1'b1;
                    fm_waddr  = '0;
                    fill_next = 6'd1;
                    crc_next  = crc_upd(CRC_INIT, hb);
                end
                else
                begin
                    disc_next = disc_reg + 32'd1;
                end
            end
            else if (fill_reg == 6'd1)
            begin
                if (!len_ok)
                begin
                    lerr_next = lerr_reg + 32'd1;
                    ev_add    = 1'b1;
                    ev_new    = '{kind: EV_BAD_LEN, flen: 6'd2, idx: 5'd0, val: 8'd0};
                    exp_next  = 6'd0;
                    if (hb == sync_reg)
                    begin
                        disc_next = disc_reg + 32'd1;
                        fm_we     = 1'b1;
                        fm_waddr  = '0;
                        fill_next = 6'd1;
                        crc_next  = crc_upd(CRC_INIT, hb);
                    end
                    else
                    begin
                        disc_next = disc_reg + 32'd2;
                        fill_next = 6'd0;
                    end
                end
                else
                begin
                    fm_we     = 1'b1;
                    fm_waddr  = 5'd1;
                    fill_next = 6'd2;
                    exp_next  = hb[5:0];
                    crc_next  = crc_upd(crc_reg, hb);
                end
            end
            else
            begin
                fm_we     = 1'b1;
                fm_waddr  = fill_reg[FRAME_AW-1:0];
                fill_next = fill_reg + 6'd1;
                if (fill_reg < exp_reg - 6'd2)
                begin
                    crc_next = crc_upd(crc_reg, hb);
                end
                else if (fill_reg == exp_reg - 6'd2)
                begin
                    lo_next = hb;
                end
                else
                begin
                    fill_next = 6'd0;
                    exp_next  = 6'd0;
                    len_next  = exp_reg;
                    if (crc_reg == {hb, lo_reg})
                    begin
                        good_next  = good_reg + 32'd1;
                        cnt_next   = 6'd0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        cerr_next    = cerr_reg + 32'd1;
                        disc_next    = disc_reg + 32'd1;
                        ev_add       = 1'b1;
                        ev_new       = '{kind: EV_BAD_CRC, flen: exp_reg, idx: 5'd0,
                                         val: 8'd0};
                        nm1          = exp_reg - 6'd1;
                        room         = 6'(MAX_FRAME) - nm1;
                        keep         = (len_base > room) ? room : len_base;
                        rq_len_next  = keep + nm1;
                        rq_head_next = head_base - nm1[4:0];
                        cnt_next     = 6'd1;
                        state_next   = S_COPY;
                    end
                end
            end
        end

        ev_we    = ev_add && (ev_cnt_reg < 7'(RES_MAX));
        ev_waddr = ev_cnt_reg[EV_AW-1:0];
        ev_wdata = ev_new;
        if (ev_we)
        begin
            ev_cnt_next = ev_cnt_reg + 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sync_reg      <= SYNC_RESET;
            min_reg       <= 6'd4;
            max_reg       <= 6'd32;
            fill_reg      <= 6'd0;
            exp_reg       <= 6'd0;
            rq_head_reg   <= 5'd0;
            rq_len_reg    <= 6'd0;
            ev_cnt_reg    <= 7'd0;
            out_idx_reg   <= 6'd0;
            rcv_reg       <= 32'd0;
            disc_reg      <= 32'd0;
            lerr_reg      <= 32'd0;
            good_reg      <= 32'd0;
            cerr_reg      <= 32'd0;
            gap_reg       <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            exp_reg       <= exp_next;
            rq_head_reg   <= rq_head_next;
            rq_len_reg    <= rq_len_next;
            ev_cnt_reg    <= ev_cnt_next;
            out_idx_reg   <= out_idx_next;
            rcv_reg       <= rcv_next;
            disc_reg      <= disc_next;
            lerr_reg      <= lerr_next;
            good_reg      <= good_next;
            cerr_reg      <= cerr_next;
            gap_reg       <= gap_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_SYNC: sync_reg <= cfg_data;
                    REG_MIN:  min_reg  <= cfg_data[5:0];
                    REG_MAX:  max_reg  <= cfg_data[5:0];
                    default:  ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg      <= crc_next;
        lo_reg       <= lo_next;
        len_reg      <= len_next;
        cnt_reg      <= cnt_next;
        out_ev_reg   <= out_ev_next;
        out_last_reg <= out_last_next;
    end

    assign in_stall              = (state_reg != S_IDLE);
    assign cfg_ready             = 1'b1;
    assign out_valid             = out_valid_reg;
    assign event_kind            = out_ev_reg.kind;
    assign frame_len             = out_ev_reg.flen;
    assign byte_index            = out_ev_reg.idx;
    assign byte_value            = out_ev_reg.val;
    assign last                  = out_last_reg;
    assign idle                  = (fill_reg == 6'd0);
    assign count_bytes_received  = rcv_reg;
    assign count_bytes_discarded = disc_reg;
    assign count_length_errors   = lerr_reg;
    assign count_frames_ok       = good_reg;
    assign count_crc_errors      = cerr_reg;
    assign count_gap_resets      = gap_reg;

endmodule
`default_nettype wire
